@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Sizes of the entry store, operation and status codes, and the entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	// Store geometry
	localparam int CAPACITY    = 64;
	localparam int IDX_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

	// Field widths
	localparam int NAME_BITS   = 16;
	localparam int PRIO_BITS   = 16;
	localparam int STAMP_BITS  = 32;
	localparam int OCC_BITS    = 7;

	// Stream word widths
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [2:0] {
		OP_INSERT  = 3'd0,
		OP_PEEK    = 3'd1,
		OP_POP     = 3'd2,
		OP_UPGRADE = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_NOMATCH = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	// One stored entry
	typedef struct packed {
		logic [NAME_BITS-1:0]  name;
		logic [PRIO_BITS-1:0]  prio;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;

	// Urgency key: lower prio first, larger age first
	typedef struct packed {
		logic [PRIO_BITS-1:0]  prio;
		logic [STAMP_BITS-1:0] age;
	} rank_t;

endpackage

`default_nettype wire

@@ hw/rtl/spq_entry_mem.sv @@
// ----------------------------------------------------------------------------
// spq_entry_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_entry_mem (
	input  wire                    clk,
	input  wire                    wr_en,
	input  wire [spq_pkg::IDX_BITS-1:0] wr_addr,
	input  spq_pkg::entry_t        wr_data,
	input  wire [spq_pkg::IDX_BITS-1:0] rd_addr,
	output spq_pkg::entry_t        rd_data
);
	import spq_pkg::*;

	entry_t mem_q [CAPACITY];
	entry_t rd_data_q;

	// Write and read the array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/spq_urgency_cmp.sv @@
// ----------------------------------------------------------------------------
// spq_urgency_cmp: shared urgency comparator
// Flags a candidate that is strictly more urgent than the current best.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_urgency_cmp (
	input  spq_pkg::rank_t cand,
	input  spq_pkg::rank_t best,
	output logic           more_urgent
);
	import spq_pkg::*;

	// Lower priority wins, then the older entry; a full tie keeps the best
	always_comb begin
		if (cand.prio != best.prio) begin
			more_urgent = (cand.prio < best.prio);
		end else begin
			more_urgent = (cand.age > best.age);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/stable_priority_queue_with_upgrade.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_with_upgrade: unsorted priority queue, 64 entries
//
// Input stream s_*: one command per transfer. Output stream m_*: exactly one
// result per command, in command order.
// Insert, peek, pop and upgrade scan every slot through one registered memory
// read port and one shared urgency comparator, one slot per cycle. Such a
// command passes through the scan, drain and finish steps before its result
// is raised; clear and undefined codes go straight to the finish step. A new
// command is taken once the previous one has finished, so the queue never
// works on more than one command at a time.
// The result sits in an output register: the next command is accepted while
// it waits. If the receiver stalls, the following command finishes its scan
// and holds in its last step until the output register frees up.
// Reset empties the queue and zeroes the sequence counter; entry contents
// are not cleared, since only the contents of valid slots are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_with_upgrade (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	// [2:0] operation, [18:3] name_id, [34:19] priority_req, rest zero
	input  wire [39:0] s_tdata,
	output logic       m_tvalid,
	input  wire        m_tready,
	// [1:0] status, [17:2] front_name_id, [33:18] front_priority,
	// [40:34] occupancy, rest zero
	output logic [47:0] m_tdata
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic [NAME_BITS-1:0]    req_name_q;
	logic [PRIO_BITS-1:0]    req_prio_q;
	logic [STAMP_BITS-1:0]   seq_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [CAPACITY-1:0]     valid_q;
	logic [IDX_BITS-1:0]     rd_idx_q;
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;

	// Scan pipeline
	logic                    vld_s1;
	logic                    last_s1;
	logic [IDX_BITS-1:0]     idx_s1;
	logic                    vld_s2;
	logic                    last_s2;
	logic                    elig_s2;
	logic [IDX_BITS-1:0]     idx_s2;
	rank_t                   rank_s2;
	logic [NAME_BITS-1:0]    name_s2;

	// Running best and lowest free slot
	logic                    best_vld_q;
	logic [IDX_BITS-1:0]     best_idx_q;
	rank_t                   best_rank_q;
	logic [NAME_BITS-1:0]    best_name_q;
	logic                    free_found_q;
	logic [IDX_BITS-1:0]     free_idx_q;

	logic                    in_xfer;
	op_t                     in_op;
	logic                    scan_last;
	logic                    more_urgent;
	entry_t                  rd_data;
	logic                    elig_s1;
	logic [STAMP_BITS-1:0]   age_s1;

	// Finish step
	logic                    fire;
	logic                    wr_req;
	logic                    mem_we;
	logic [IDX_BITS-1:0]     mem_waddr;
	entry_t                  mem_wdata;
	logic                    set_valid;
	logic                    clr_valid;
	logic                    clr_all;
	status_t                 status;
	logic [NAME_BITS-1:0]    fname;
	logic [PRIO_BITS-1:0]    fprio;
	logic [COUNT_BITS-1:0]   count_nxt;
	logic                    is_full;

	assign s_tready  = (state_q == S_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign in_op     = op_t'(s_tdata[2:0]);
	assign scan_last = (rd_idx_q == IDX_BITS'(CAPACITY - 1));
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign is_full   = (count_q == COUNT_BITS'(CAPACITY));
	assign fire      = (state_q == S_FINISH) && (!m_tvalid_q || m_tready);
	assign mem_we    = fire && wr_req;

	spq_entry_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	spq_urgency_cmp u_cmp (
		.cand        (rank_s2),
		.best        (best_rank_q),
		.more_urgent (more_urgent)
	);

	// Qualify the slot that the memory returns
	always_comb begin
		age_s1 = seq_q - rd_data.stamp;
		case (op_q)
			OP_PEEK, OP_POP: begin
				elig_s1 = valid_q[idx_s1];
			end
			OP_UPGRADE: begin
				elig_s1 = valid_q[idx_s1] && (rd_data.name == req_name_q) &&
					(rd_data.prio > req_prio_q);
			end
			default: begin
				elig_s1 = 1'b0;
			end
		endcase
	end

	// Advance the scan pipeline and keep the running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
			idx_s1       <= '0;
			vld_s2       <= 1'b0;
			last_s2      <= 1'b0;
			elig_s2      <= 1'b0;
			idx_s2       <= '0;
			rank_s2      <= '0;
			name_s2      <= '0;
			best_vld_q   <= 1'b0;
			best_idx_q   <= '0;
			best_rank_q  <= '0;
			best_name_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else begin
			vld_s1  <= (state_q == S_SCAN);
			last_s1 <= (state_q == S_SCAN) && scan_last;
			idx_s1  <= rd_idx_q;

			vld_s2  <= vld_s1;
			last_s2 <= vld_s1 && last_s1;
			elig_s2 <= vld_s1 && elig_s1;
			idx_s2  <= idx_s1;
			rank_s2 <= '{prio: rd_data.prio, age: age_s1};
			name_s2 <= rd_data.name;

			if (in_xfer) begin
				best_vld_q   <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				// Take the lowest free slot
				if (vld_s1 && !valid_q[idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
				// Take the first eligible slot, then replace the best only on strictly higher urgency
				if (vld_s2 && elig_s2 && (!best_vld_q || more_urgent)) begin
					best_vld_q  <= 1'b1;
					best_idx_q  <= idx_s2;
					best_rank_q <= rank_s2;
					best_name_q <= name_s2;
				end
			end
		end
	end

	// Decide the outcome once the scan is over
	always_comb begin
		wr_req    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = '{name: best_name_q, prio: req_prio_q, stamp: seq_q};
		set_valid = 1'b0;
		clr_valid = 1'b0;
		clr_all   = 1'b0;
		status    = STAT_OK;
		fname     = '0;
		fprio     = '0;
		count_nxt = count_q;
		case (op_q)
			OP_INSERT: begin
				if (is_full) begin
					status = STAT_FULL;
				end else begin
					wr_req    = 1'b1;
					mem_waddr = free_idx_q;
					mem_wdata = '{name: req_name_q, prio: req_prio_q, stamp: seq_q};
					set_valid = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			OP_PEEK, OP_POP: begin
				if (!best_vld_q) begin
					status = STAT_EMPTY;
				end else begin
					fname = best_name_q;
					fprio = best_rank_q.prio;
					if (op_q == OP_POP) begin
						clr_valid = 1'b1;
						count_nxt = count_q - 1'b1;
					end
				end
			end
			OP_UPGRADE: begin
				if (!best_vld_q) begin
					status = STAT_NOMATCH;
				end else begin
					wr_req = 1'b1;
				end
			end
			OP_CLEAR: begin
				clr_all   = 1'b1;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequence commands and hold the registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_INSERT;
			req_name_q <= '0;
			req_prio_q <= '0;
			seq_q      <= '0;
			count_q    <= '0;
			valid_q    <= '0;
			rd_idx_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// Raise the result when a command finishes, drop it once taken
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q       <= in_op;
						req_name_q <= s_tdata[3 +: NAME_BITS];
						req_prio_q <= s_tdata[3 + NAME_BITS +: PRIO_BITS];
						rd_idx_q   <= '0;
						case (in_op)
							OP_INSERT, OP_PEEK, OP_POP, OP_UPGRADE: begin
								seq_q   <= seq_q + 1'b1;
								state_q <= S_SCAN;
							end
							OP_CLEAR: begin
								seq_q   <= seq_q + 1'b1;
								state_q <= S_FINISH;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (vld_s2 && last_s2) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fire) begin
						m_tdata_q  <= {(OUT_TDATA_W - 2 - NAME_BITS - PRIO_BITS - OCC_BITS)'(0),
							OCC_BITS'(count_nxt), fprio, fname, status};
						count_q    <= count_nxt;
						if (clr_all) begin
							valid_q <= '0;
						end else if (set_valid) begin
							valid_q[free_idx_q] <= 1'b1;
						end else if (clr_valid) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Occupancy never exceeds the store
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(CAPACITY))
		else $error("occupancy above capacity");

	// Occupancy tracks the valid bits
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q == COUNT_BITS'($countones(valid_q)))
		else $error("occupancy out of step with valid bits");

	// A new result only leaves from the finish step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside finish step");

	// The chosen entry is a live one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && best_vld_q && op_q != OP_CLEAR && op_q != OP_INSERT)
			|-> valid_q[best_idx_q])
		else $error("best entry is not valid");

endmodule

`default_nettype wire
